/* sv/trc_pkg.sv */
// shared constants, types and codes for the tag receiver and mode decider
package trc_pkg;

	localparam int CHAR_W             = 8;
	localparam int MAX_CHARS          = 12;
	localparam int HALF_CHARS         = 6;
	localparam int TAG_W              = CHAR_W * HALF_CHARS;
	localparam int CNT_W              = 4;
	localparam int TAG_LENGTH_DEFAULT = 12;

	localparam logic [CHAR_W-1:0] BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CASE_GAP  = 8'd32;

	localparam logic [TAG_W-1:0] MASTER_HIGH_RESET = 48'h313830303844;
	localparam logic [TAG_W-1:0] MASTER_LOW_RESET  = 48'h433032453742;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_LOW  = 2'd1;

	typedef enum logic [1:0] {
		ACT_ENTER_ADD  = 2'd0,
		ACT_CLEAR_ALL  = 2'd1,
		ACT_SAVE_CARD  = 2'd2,
		ACT_CHECK_CARD = 2'd3
	} action_t;

	typedef struct packed {
		logic              is_backspace;
		logic              keep;
		logic [CHAR_W-1:0] ch;
	} char_info_t;

endpackage

/* sv/trc_if.sv */
// stream interfaces for received bytes and emitted decisions
interface trc_rx_if;
	logic                       valid;
	logic                       ready;
	logic [trc_pkg::CHAR_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface trc_dec_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [trc_pkg::TAG_W-1:0] tag_high;
	logic [trc_pkg::TAG_W-1:0] tag_low;
	logic                      add_mode;

	modport source (output valid, output action, output tag_high, output tag_low,
		output add_mode, input ready);
	modport sink (input valid, input action, input tag_high, input tag_low,
		input add_mode, output ready);
endinterface

/* sv/trc_char_class.sv */
// classifies one received byte: backspace, kept character (folded to uppercase) or dropped
module trc_char_class (
	input  logic [trc_pkg::CHAR_W-1:0] rx_byte,
	output trc_pkg::char_info_t        info
);

	logic                       is_lower;
	logic [trc_pkg::CHAR_W-1:0] upper;
	logic                       is_digit;
	logic                       is_alpha;

	always_comb begin
		is_lower = (rx_byte >= "a") && (rx_byte <= "z");
		upper    = is_lower ? (rx_byte - trc_pkg::CASE_GAP) : rx_byte;
		is_digit = (upper >= "0") && (upper <= "9");
		is_alpha = (upper >= "A") && (upper <= "Z");

		info.is_backspace = (rx_byte == trc_pkg::BACKSPACE);
		info.keep         = is_digit || is_alpha;
		info.ch           = upper;
	end

endmodule

/* sv/trc_tag_core.sv */
// character buffer, count, master compare, add mode and the decision output register
module trc_tag_core #(
	parameter int TAG_LENGTH = trc_pkg::TAG_LENGTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  trc_pkg::char_info_t       info,
	input  logic [trc_pkg::TAG_W-1:0] master_high,
	input  logic [trc_pkg::TAG_W-1:0] master_low,
	output logic                      take,
	trc_dec_if.source                 dec
);

	localparam int TAG_LEN = (TAG_LENGTH < 1) ? 1 :
		((TAG_LENGTH > trc_pkg::MAX_CHARS) ? trc_pkg::MAX_CHARS : TAG_LENGTH);
	localparam int ALL_W = 2 * trc_pkg::TAG_W;

	logic [trc_pkg::CHAR_W-1:0] buf_q    [trc_pkg::MAX_CHARS];
	logic [trc_pkg::CHAR_W-1:0] buf_next [trc_pkg::MAX_CHARS];
	logic [trc_pkg::CNT_W-1:0]  count_q;
	logic                       mode_q;

	logic                       out_valid_q;
	trc_pkg::action_t           action_q;
	logic [trc_pkg::TAG_W-1:0]  tag_high_q;
	logic [trc_pkg::TAG_W-1:0]  tag_low_q;
	logic                       add_mode_q;

	logic                       advance;
	logic                       store;
	logic                       last;
	logic [ALL_W-1:0]           tag_all;
	logic [ALL_W-1:0]           master_all;
	logic                       match;
	trc_pkg::action_t           action_d;
	logic                       mode_d;

	assign advance = !out_valid_q || dec.ready;
	assign take    = item_valid && advance;
	assign store   = take && info.keep && !info.is_backspace;
	assign last    = store && (count_q == trc_pkg::CNT_W'(TAG_LEN - 1));

	assign master_all = {master_high, master_low};

	// the character arriving now completes the tag, so compare on the updated buffer
	always_comb begin
		tag_all = '0;
		match   = 1'b1;
		for (int i = 0; i < trc_pkg::MAX_CHARS; i++) begin
			buf_next[i] = (store && (count_q == trc_pkg::CNT_W'(i))) ? info.ch : buf_q[i];
			if (i < TAG_LEN) begin
				tag_all[trc_pkg::CHAR_W*(trc_pkg::MAX_CHARS-1-i) +: trc_pkg::CHAR_W] =
					buf_next[i];
				if (buf_next[i] !=
					master_all[trc_pkg::CHAR_W*(trc_pkg::MAX_CHARS-1-i) +: trc_pkg::CHAR_W])
					match = 1'b0;
			end
		end
	end

	always_comb begin
		if (match) begin
			action_d = mode_q ? trc_pkg::ACT_CLEAR_ALL : trc_pkg::ACT_ENTER_ADD;
			mode_d   = !mode_q;
		end else begin
			action_d = mode_q ? trc_pkg::ACT_SAVE_CARD : trc_pkg::ACT_CHECK_CARD;
			mode_d   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			buf_q <= buf_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= 1'b0;
		end else if (take) begin
			if (info.is_backspace) begin
				if (count_q != '0) begin
					count_q <= count_q - trc_pkg::CNT_W'(1);
				end
			end else if (last) begin
				count_q <= '0;
				mode_q  <= mode_d;
			end else if (store) begin
				count_q <= count_q + trc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (last) begin
			action_q   <= action_d;
			tag_high_q <= tag_all[ALL_W-1 -: trc_pkg::TAG_W];
			tag_low_q  <= tag_all[trc_pkg::TAG_W-1:0];
			add_mode_q <= mode_d;
		end
	end

	assign dec.valid    = out_valid_q;
	assign dec.action   = action_q;
	assign dec.tag_high = tag_high_q;
	assign dec.tag_low  = tag_low_q;
	assign dec.add_mode = add_mode_q;

endmodule

/* sv/tag_receiver_and_mode_decider.sv */
// top level: input register, master tag registers, byte classifier and tag core
// Takes one received byte per cycle while the decision port does not stall. A byte is
// registered in the input register on acceptance and processed once the tag core takes it;
// the decision for the byte that completes the tag is registered in the output register and
// held there until taken; bytes keep flowing at one per cycle as long as the decision port
// does not stall. Backspace removes the last stored character, letters are folded to
// uppercase and anything else that is not a letter or digit is dropped. The master tag lives
// in two 48-bit registers (index 0 high half, index 1 low half, first character in the top
// byte); write them only while no bytes are in flight.
module tag_receiver_and_mode_decider #(
	parameter int TAG_LENGTH = trc_pkg::TAG_LENGTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [trc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [trc_pkg::TAG_W-1:0]     cfg_wdata,
	trc_rx_if.sink                        rx,
	trc_dec_if.source                     dec
);

	logic                       rx_valid_s1;
	logic [trc_pkg::CHAR_W-1:0] rx_byte_s1;
	logic [trc_pkg::TAG_W-1:0]  master_high_q;
	logic [trc_pkg::TAG_W-1:0]  master_low_q;
	trc_pkg::char_info_t        info;
	logic                       take;

	assign rx.ready = !rx_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			rx_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_high_q <= trc_pkg::MASTER_HIGH_RESET;
			master_low_q  <= trc_pkg::MASTER_LOW_RESET;
		end else if (cfg_we) begin
			if (cfg_index == trc_pkg::REG_MASTER_HIGH) begin
				master_high_q <= cfg_wdata;
			end else if (cfg_index == trc_pkg::REG_MASTER_LOW) begin
				master_low_q <= cfg_wdata;
			end
		end
	end

	trc_char_class u_char_class (
		.rx_byte (rx_byte_s1),
		.info    (info)
	);

	trc_tag_core #(
		.TAG_LENGTH (TAG_LENGTH)
	) u_tag_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (rx_valid_s1),
		.info        (info),
		.master_high (master_high_q),
		.master_low  (master_low_q),
		.take        (take),
		.dec         (dec)
	);

endmodule

/* dv/tag_receiver_and_mode_decider_tb.sv */
// self-checking testbench for the tag receiver and mode decider
`timescale 1ns / 1ps

module tag_receiver_and_mode_decider_tb;

	localparam int CHAR_W = trc_pkg::CHAR_W;
	localparam int TAG_W = trc_pkg::TAG_W;
	localparam int CFG_IDX_W = trc_pkg::CFG_IDX_W;
	localparam int MAX_CHARS = trc_pkg::MAX_CHARS;
	localparam int HALF_CHARS = trc_pkg::HALF_CHARS;
	localparam int TAG_LEN = trc_pkg::TAG_LENGTH_DEFAULT;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 33;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		trc_pkg::action_t action;
		logic [TAG_W-1:0] tag_high;
		logic [TAG_W-1:0] tag_low;
		logic             add_mode;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TAG_W-1:0] cfg_wdata;

	trc_rx_if  rx_bus ();
	trc_dec_if dec_bus ();

	tag_receiver_and_mode_decider #(.TAG_LENGTH(TAG_LEN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx       (rx_bus),
		.dec      (dec_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bytes waiting to be sent and decisions the predictor has worked out
	logic [CHAR_W-1:0] byte_backlog[$];
	decision_t decisions_due[$];

	// predictor state
	logic [TAG_W-1:0] master_high = trc_pkg::MASTER_HIGH_RESET;
	logic [TAG_W-1:0] master_low = trc_pkg::MASTER_LOW_RESET;
	logic [CHAR_W-1:0] stored_tag[MAX_CHARS];
	int stored_chars = 0;
	logic in_add_mode = 1'b0;

	int bytes_accepted = 0;
	int bytes_queued = 0;
	int decisions_seen = 0;
	int mismatches = 0;
	int action_tally[4] = '{0, 0, 0, 0};
	int hold_left = 0;
	bit stall_done = 0;
	int cycles = 0;
	bit tx_idle;
	bit rx_calm;

	// generator side: character count as it will be once the backlog is sent
	int gen_count = 0;
	logic [CHAR_W-1:0] draft_tag[MAX_CHARS];

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] b);
		if (b >= "a" && b <= "z")
			return b - trc_pkg::CASE_GAP;
		return b;
	endfunction

	function automatic bit is_tag_char(input logic [CHAR_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [CHAR_W-1:0] master_char(input int pos);
		if (pos < HALF_CHARS)
			return master_high[CHAR_W*(HALF_CHARS-1-pos) +: CHAR_W];
		return master_low[CHAR_W*(MAX_CHARS-1-pos) +: CHAR_W];
	endfunction

	function automatic logic [CHAR_W-1:0] random_alnum();
		int r;
		r = $urandom_range(0, 35);
		if (r < 10)
			return CHAR_W'("0" + r);
		return CHAR_W'("A" + (r - 10));
	endfunction

	function automatic logic [CHAR_W-1:0] random_noise();
		logic [CHAR_W-1:0] b;
		do
			b = CHAR_W'($urandom_range(0, 255));
		while (is_tag_char(fold_case(b)) || b == trc_pkg::BACKSPACE);
		return b;
	endfunction

	function automatic logic [TAG_W-1:0] random_alnum_half();
		logic [TAG_W-1:0] v;
		for (int i = 0; i < HALF_CHARS; i++)
			v[CHAR_W*i +: CHAR_W] = random_alnum();
		return v;
	endfunction

	function automatic bit master_reachable();
		for (int i = 0; i < TAG_LEN; i++)
			if (!is_tag_char(master_char(i)))
				return 0;
		return 1;
	endfunction

	// applies one accepted byte to the predictor, queues a decision when the tag completes
	task automatic absorb_byte(input logic [CHAR_W-1:0] raw);
		logic [CHAR_W-1:0] c;
		decision_t d;
		bit match;
		if (raw == trc_pkg::BACKSPACE) begin
			if (stored_chars > 0)
				stored_chars--;
			return;
		end
		c = fold_case(raw);
		if (!is_tag_char(c))
			return;
		if (stored_chars < MAX_CHARS)
			stored_tag[stored_chars] = c;
		stored_chars++;
		if (stored_chars < TAG_LEN)
			return;
		match = 1;
		d.tag_high = '0;
		d.tag_low = '0;
		for (int i = 0; i < TAG_LEN; i++) begin
			if (stored_tag[i] != master_char(i))
				match = 0;
			if (i < HALF_CHARS)
				d.tag_high[CHAR_W*(HALF_CHARS-1-i) +: CHAR_W] = stored_tag[i];
			else
				d.tag_low[CHAR_W*(MAX_CHARS-1-i) +: CHAR_W] = stored_tag[i];
		end
		if (match) begin
			d.action = in_add_mode ? trc_pkg::ACT_CLEAR_ALL : trc_pkg::ACT_ENTER_ADD;
			in_add_mode = !in_add_mode;
		end else begin
			d.action = in_add_mode ? trc_pkg::ACT_SAVE_CARD : trc_pkg::ACT_CHECK_CARD;
			in_add_mode = 1'b0;
		end
		d.add_mode = in_add_mode;
		stored_chars = 0;
		decisions_due.push_back(d);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
			rx_bus.rx_byte <= '0;
		end else begin
			if (rx_bus.valid && rx_bus.ready) begin
				absorb_byte(rx_bus.rx_byte);
				bytes_accepted++;
			end
			if (!rx_bus.valid || rx_bus.ready) begin
				tx_idle = (bytes_accepted >= 400 && bytes_accepted < 600) ? 1'b0
					: ($urandom_range(0, 99) < IDLE_PCT);
				if (byte_backlog.size() > 0 && !tx_idle) begin
					rx_bus.valid <= 1'b1;
					rx_bus.rx_byte <= byte_backlog.pop_front();
				end else begin
					rx_bus.valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_bus.ready <= 1'b0;
		end else begin
			if (dec_bus.valid && dec_bus.ready) begin
				if (decisions_due.size() == 0) begin
					$display("%0t: unexpected decision action=%0d tag=%h_%h add_mode=%0b", $time,
						dec_bus.action, dec_bus.tag_high, dec_bus.tag_low, dec_bus.add_mode);
					mismatches++;
				end else begin
					decision_t want;
					want = decisions_due.pop_front();
					if (dec_bus.action !== want.action) begin
						$display("%0t: action expected %0d, got %0d", $time, want.action,
							dec_bus.action);
						mismatches++;
					end
					if (dec_bus.tag_high !== want.tag_high) begin
						$display("%0t: tag_high expected %h, got %h", $time, want.tag_high,
							dec_bus.tag_high);
						mismatches++;
					end
					if (dec_bus.tag_low !== want.tag_low) begin
						$display("%0t: tag_low expected %h, got %h", $time, want.tag_low,
							dec_bus.tag_low);
						mismatches++;
					end
					if (dec_bus.add_mode !== want.add_mode) begin
						$display("%0t: add_mode expected %0b, got %0b", $time, want.add_mode,
							dec_bus.add_mode);
						mismatches++;
					end
				end
				action_tally[dec_bus.action]++;
				decisions_seen++;
			end
			// one long hold-off so the output register backs up into the input
			rx_calm = decisions_seen >= 40 && decisions_seen < 55;
			if (hold_left > 0) begin
				hold_left--;
				dec_bus.ready <= 1'b0;
			end else if (!stall_done && decisions_seen >= 15) begin
				stall_done = 1;
				hold_left = HOLD_CYCLES - 1;
				dec_bus.ready <= 1'b0;
			end else begin
				dec_bus.ready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d decisions still due", $time, decisions_due.size());
			$display("[tag_receiver_and_mode_decider] ERROR");
			$finish;
		end
	end

	task automatic queue_byte(input logic [CHAR_W-1:0] b);
		byte_backlog.push_back(b);
		bytes_queued++;
		if (b == trc_pkg::BACKSPACE) begin
			if (gen_count > 0)
				gen_count--;
		end else if (is_tag_char(fold_case(b))) begin
			gen_count++;
			if (gen_count >= TAG_LEN)
				gen_count = 0;
		end
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	// sends draft_tag with random case, stray noise and corrected typos
	task automatic queue_draft();
		logic [CHAR_W-1:0] c;
		if (gen_count > 0 && $urandom_range(0, 99) < 85)
			repeat (gen_count) queue_byte(trc_pkg::BACKSPACE);
		for (int i = 0; i < TAG_LEN; i++) begin
			if ($urandom_range(0, 99) < 10)
				queue_byte(random_noise());
			if ($urandom_range(0, 99) < 8) begin
				queue_byte(random_alnum());
				queue_byte(trc_pkg::BACKSPACE);
			end
			c = draft_tag[i];
			if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
				c = c + trc_pkg::CASE_GAP;
			queue_byte(c);
		end
	endtask

	task automatic random_phase(input int budget);
		int stop_at;
		int r;
		int pos;
		stop_at = bytes_queued + budget;
		while (bytes_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				for (int i = 0; i < TAG_LEN; i++)
					draft_tag[i] = master_reachable() ? master_char(i) : random_alnum();
				if (!master_reachable() || r >= 35) begin
					if (r < 55) begin
						pos = $urandom_range(0, TAG_LEN - 1);
						do
							draft_tag[pos] = random_alnum();
						while (draft_tag[pos] == master_char(pos));
					end else begin
						for (int i = 0; i < TAG_LEN; i++)
							draft_tag[i] = random_alnum();
					end
				end
				queue_draft();
			end else if (r < 88) begin
				repeat ($urandom_range(1, 12)) queue_byte(CHAR_W'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4)) queue_byte(trc_pkg::BACKSPACE);
				repeat ($urandom_range(0, 5)) queue_byte(random_alnum());
			end
		end
	endtask

	// nothing queued, nothing in flight, nothing due
	task automatic drain();
		@(negedge clk);
		while (byte_backlog.size() > 0 || rx_bus.valid || decisions_due.size() > 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == trc_pkg::REG_MASTER_HIGH)
			master_high = data;
		else if (idx == trc_pkg::REG_MASTER_LOW)
			master_low = data;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset master tag, typed in lower case with noise, a typo and backspaces
		queue_byte(trc_pkg::BACKSPACE);
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h7F);
		queue_text("18008d");
		queue_text("x");
		queue_byte(trc_pkg::BACKSPACE);
		queue_text("@c[0");
		queue_byte(8'h60);
		queue_text("2{e/7:b");
		random_phase(190);
		drain();

		write_reg(trc_pkg::REG_MASTER_HIGH, random_alnum_half());
		write_reg(trc_pkg::REG_MASTER_LOW, random_alnum_half());
		// writes beyond the register list must leave the master tag alone
		write_reg(REG_SPARE_2, {TAG_W{1'b1}});
		write_reg(REG_SPARE_3, TAG_W'({$urandom, $urandom}));
		random_phase(200);
		drain();

		write_reg(trc_pkg::REG_MASTER_HIGH, '0);
		write_reg(trc_pkg::REG_MASTER_LOW, '0);
		random_phase(120);
		drain();

		write_reg(trc_pkg::REG_MASTER_HIGH, {TAG_W{1'b1}});
		write_reg(trc_pkg::REG_MASTER_LOW, {TAG_W{1'b1}});
		random_phase(120);
		drain();

		write_reg(trc_pkg::REG_MASTER_HIGH, TAG_W'({$urandom, $urandom}));
		write_reg(trc_pkg::REG_MASTER_LOW, TAG_W'({$urandom, $urandom}));
		random_phase(80);
		drain();

		write_reg(trc_pkg::REG_MASTER_HIGH, random_alnum_half());
		write_reg(trc_pkg::REG_MASTER_LOW, random_alnum_half());
		random_phase(200);
		drain();
		repeat (10) @(posedge clk);

		$display("%0d bytes sent, %0d decisions: enter add %0d, clear all %0d, save %0d, check %0d",
			bytes_accepted, decisions_seen, action_tally[trc_pkg::ACT_ENTER_ADD],
			action_tally[trc_pkg::ACT_CLEAR_ALL], action_tally[trc_pkg::ACT_SAVE_CARD],
			action_tally[trc_pkg::ACT_CHECK_CARD]);
		$display("six master tag settings incl. all-zero and all-one, %0d-cycle output stall",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("[tag_receiver_and_mode_decider] OK");
		else
			$display("[tag_receiver_and_mode_decider] ERROR");
		$finish;
	end

endmodule
